// ===== rtl/sac_pkg.sv =====
// sac_pkg: shared types and constants of the sink accretion classifier
// used by the queue, front, back and top level; depends on nothing
package sac_pkg;

  localparam int unsigned AXES       = 3;
  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 64;

  // configuration register indexes
  localparam logic [2:0] REG_HOLE_X    = 3'd0;
  localparam logic [2:0] REG_HOLE_Y    = 3'd1;
  localparam logic [2:0] REG_HOLE_Z    = 3'd2;
  localparam logic [2:0] REG_GRAV_MASS = 3'd3;
  localparam logic [2:0] REG_SOFTEN_SQ = 3'd4;
  localparam logic [2:0] REG_SINK_RAD  = 3'd5;
  localparam logic [2:0] REG_SINK_ON   = 3'd6;

  localparam logic [47:0] GRAV_MASS_RST = 48'd6553600000;
  localparam logic [62:0] SOFTEN_SQ_RST = 63'd4295;
  localparam logic [62:0] SINK_RAD_RST  = 63'd107374;

  // one classified particle handed from front to back
  typedef struct packed {
    logic        pass;   // passed sink enable, ghost, radius and inflow tests
    logic [63:0] rs;     // r2 + soften_sq, saturated
    logic [46:0] ke;     // 0.5 |v|^2, Q31.16
    logic [31:0] mass;
  } sac_job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROOT,
    B_DIV,
    B_DONE
  } sac_back_state_t;

endpackage

// ===== rtl/sac_queue.sv =====
// sac_queue: small first-in first-out queue of classified particles
// depends on sac_pkg for the job type
module sac_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sac_pkg::sac_job_t push_job,
  output logic              not_full,
  input  logic              pop,
  output sac_pkg::sac_job_t pop_job,
  output logic              not_empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  sac_pkg::sac_job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign not_full  = (fill != FULL);
  assign not_empty = (fill != '0);
  assign pop_job   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/sac_front.sv =====
// sac_front: accepts particles, forms distances and products, runs the
// radius and inflow tests and hands a job to the queue; uses sac_pkg
module sac_front #(
  parameter int unsigned DIMENSIONS = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [223:0]      in_data,
  input  logic              in_ghost,
  input  logic [95:0]       hole,
  input  logic [62:0]       soften_sq,
  input  logic [62:0]       sink_rad_sq,
  input  logic              sink_on,
  output logic              push,
  output sac_pkg::sac_job_t push_job,
  input  logic              q_not_full
);

  localparam int unsigned A = sac_pkg::AXES;

  logic        v1, v2, v3;
  logic        advance;
  // stage 1
  logic [31:0] md [A];
  logic [31:0] mv [A];
  logic        opp1 [A];
  logic        gate1, gate2, gate3;
  logic [31:0] mass1, mass2, mass3;
  // stage 2
  logic [63:0] dsq [A];
  logic [63:0] vd  [A];
  logic [63:0] vsq [A];
  logic        opp2 [A];
  // stage 3
  logic [65:0] r2;
  logic [63:0] pos_dot, neg_dot, vsum;
  logic [64:0] rs_sum;

  assign advance  = !(v3 && !q_not_full);
  assign in_ready = advance;
  assign push     = v3 && q_not_full;

  // valid bits of the three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // stages 1 and 2: offsets from the hole and magnitudes, then their products
  for (genvar k = 0; k < A; k++) begin : g_axis
    logic signed [32:0] d;
    logic signed [31:0] vel;
    assign d   = {in_data[32*k+31], in_data[32*k +: 32]} - {hole[32*k+31], hole[32*k +: 32]};
    assign vel = in_data[96+32*k +: 32];

    always_ff @(posedge clk) begin
      if (advance) begin
        if (k < DIMENSIONS) begin
          md[k]   <= d[32] ? 32'(-d) : d[31:0];
          mv[k]   <= vel[31] ? 32'(-vel) : vel;
          opp1[k] <= d[32] != vel[31];
        end else begin
          md[k]   <= '0;
          mv[k]   <= '0;
          opp1[k] <= 1'b0;
        end
        dsq[k]  <= 64'(md[k]) * 64'(md[k]);
        vd[k]   <= 64'(mv[k]) * 64'(md[k]);
        vsq[k]  <= 64'(mv[k]) * 64'(mv[k]);
        opp2[k] <= opp1[k];
      end
    end
  end

  // flag and mass carried along, stage 3 sums
  always_ff @(posedge clk) begin
    if (advance) begin
      gate1   <= sink_on && !in_ghost;
      mass1   <= in_data[223:192];
      gate2   <= gate1;
      mass2   <= mass1;
      gate3   <= gate2;
      mass3   <= mass2;
      r2      <= 66'(dsq[0]) + 66'(dsq[1]) + 66'(dsq[2]);
      pos_dot <= (opp2[0] ? 64'd0 : vd[0]) + (opp2[1] ? 64'd0 : vd[1])
               + (opp2[2] ? 64'd0 : vd[2]);
      neg_dot <= (opp2[0] ? vd[0] : 64'd0) + (opp2[1] ? vd[1] : 64'd0)
               + (opp2[2] ? vd[2] : 64'd0);
      vsum    <= vsq[0] + vsq[1] + vsq[2];
    end
  end

  // classification at hand-off
  assign rs_sum = {1'b0, r2[63:0]} + {2'b0, soften_sq};
  always_comb begin
    push_job.pass = gate3 && (r2[65:64] == 2'b00) && (r2[63:0] < {1'b0, sink_rad_sq})
                    && (neg_dot > pos_dot);
    push_job.rs   = rs_sum[64] ? '1 : rs_sum[63:0];
    push_job.ke   = vsum[63:17];
    push_job.mass = mass3;
  end

endmodule

// ===== rtl/sac_back.sv =====
// sac_back: square root and divide for the binding test, then the
// saturating totals and the result register; uses sac_pkg
module sac_back (
  input  logic              clk,
  input  logic              rst,
  input  sac_pkg::sac_job_t job,
  input  logic              job_valid,
  output logic              job_pop,
  input  logic [47:0]       grav_mass,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_accrete,
  output logic [31:0]       out_count,
  output logic [47:0]       out_mass
);

  sac_pkg::sac_back_state_t state, state_next;

  logic        pass;
  logic [46:0] ke;
  logic [31:0] mass;
  logic [63:0] rad;
  logic [33:0] rem;
  logic [31:0] root;
  logic [5:0]  cnt;
  logic [63:0] dvd;
  logic [32:0] drem;
  logic [63:0] quo;
  logic [31:0] total_count;
  logic [47:0] total_mass;

  logic [33:0] rem_sh, trial;
  logic        root_ge;
  logic [32:0] drem_sh;
  logic        div_ge;
  logic        finish, hit, root_last, div_last;
  logic [48:0] mass_sum;

  assign rem_sh    = {rem[31:0], rad[63:62]};
  assign trial     = {root, 2'b01};
  assign root_ge   = rem_sh >= trial;
  assign drem_sh   = {drem[31:0], dvd[63]};
  assign div_ge    = drem_sh >= {1'b0, root};
  assign root_last = cnt == 6'(sac_pkg::ROOT_STEPS - 1);
  assign div_last  = cnt == 6'(sac_pkg::DIV_STEPS - 1);
  assign hit       = pass && ((root == '0) || ({17'd0, ke} < quo));
  assign mass_sum  = {1'b0, total_mass} + 49'(mass);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sac_pkg::B_IDLE: if (job_valid) state_next = job.pass ? sac_pkg::B_ROOT : sac_pkg::B_DONE;
      sac_pkg::B_ROOT: if (root_last) state_next = sac_pkg::B_DIV;
      sac_pkg::B_DIV:  if (root == '0 || div_last) state_next = sac_pkg::B_DONE;
      sac_pkg::B_DONE: if (!out_valid || out_ready) state_next = sac_pkg::B_IDLE;
      default:         state_next = sac_pkg::B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    job_pop = 1'b0;
    finish  = 1'b0;
    unique case (state)
      sac_pkg::B_IDLE: job_pop = job_valid;
      sac_pkg::B_DONE: finish  = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sac_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // root and divide datapath
  always_ff @(posedge clk) begin
    if (job_pop) begin
      pass <= job.pass;
      ke   <= job.ke;
      mass <= job.mass;
      rad  <= job.rs;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (state == sac_pkg::B_ROOT) begin
      rad  <= {rad[61:0], 2'b00};
      rem  <= root_ge ? rem_sh - trial : rem_sh;
      root <= {root[30:0], root_ge};
      cnt  <= root_last ? '0 : cnt + 1'b1;
      dvd  <= {grav_mass, 16'd0};
      drem <= '0;
    end else if (state == sac_pkg::B_DIV) begin
      dvd  <= {dvd[62:0], 1'b0};
      drem <= div_ge ? drem_sh - {1'b0, root} : drem_sh;
      quo  <= {quo[62:0], div_ge};
      cnt  <= cnt + 1'b1;
    end
  end

  // running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      total_count <= '0;
      total_mass  <= '0;
    end else if (finish && hit) begin
      if (total_count != '1) total_count <= total_count + 1'b1;
      total_mass <= mass_sum[48] ? '1 : mass_sum[47:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_accrete <= hit;
      out_count   <= (hit && total_count != '1) ? total_count + 1'b1 : total_count;
      out_mass    <= hit ? (mass_sum[48] ? '1 : mass_sum[47:0]) : total_mass;
    end
  end

endmodule

// ===== rtl/sink_accretion_classifier.sv =====
// sink_accretion_classifier: top level with the register port, front,
// queue and back; depends on sac_pkg, sac_front, sac_queue, sac_back
//
// One particle in, one decision out, in order. The front accepts a word
// every cycle while its last stage can hand off to the queue and passes it
// through three stages (offsets, products, sums). For a word that fails the
// sink enable, ghost, radius or inflow test the back pops it and then posts
// the result; for one that passes it pops the word, runs a bit-serial square
// root, then a bit-serial divide (cut short when the root is zero), and then
// posts the result. Sustained throughput
// is therefore set by the back's iterative root and divider. The result
// register lets the back pop and work on the next word while a result
// still waits; it posts that word only once the waiting result is taken.
module sink_accretion_classifier #(
  parameter int unsigned DIMENSIONS  = 3,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, part_mass
  input  logic [223:0] s_tdata,
  // ghost
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // total_count, total_mass
  output logic [79:0]  m_tdata,
  // accrete
  output logic         m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  logic [31:0] hole_x, hole_y, hole_z;
  logic [47:0] grav_mass;
  logic [62:0] soften_sq, sink_rad_sq;
  logic        sink_on;
  logic [2:0]  reg_idx;
  logic        wr_en;

  sac_pkg::sac_job_t push_job, pop_job;
  logic push, pop, q_not_full, q_not_empty;
  logic [31:0] out_count;
  logic [47:0] out_mass;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hole_x      <= '0;
      hole_y      <= '0;
      hole_z      <= '0;
      grav_mass   <= sac_pkg::GRAV_MASS_RST;
      soften_sq   <= sac_pkg::SOFTEN_SQ_RST;
      sink_rad_sq <= sac_pkg::SINK_RAD_RST;
      sink_on     <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        sac_pkg::REG_HOLE_X:    hole_x      <= pwdata[31:0];
        sac_pkg::REG_HOLE_Y:    hole_y      <= pwdata[31:0];
        sac_pkg::REG_HOLE_Z:    hole_z      <= pwdata[31:0];
        sac_pkg::REG_GRAV_MASS: grav_mass   <= pwdata[47:0];
        sac_pkg::REG_SOFTEN_SQ: soften_sq   <= pwdata[62:0];
        sac_pkg::REG_SINK_RAD:  sink_rad_sq <= pwdata[62:0];
        sac_pkg::REG_SINK_ON:   sink_on     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      sac_pkg::REG_HOLE_X:    prdata = {32'd0, hole_x};
      sac_pkg::REG_HOLE_Y:    prdata = {32'd0, hole_y};
      sac_pkg::REG_HOLE_Z:    prdata = {32'd0, hole_z};
      sac_pkg::REG_GRAV_MASS: prdata = {16'd0, grav_mass};
      sac_pkg::REG_SOFTEN_SQ: prdata = {1'b0, soften_sq};
      sac_pkg::REG_SINK_RAD:  prdata = {1'b0, sink_rad_sq};
      sac_pkg::REG_SINK_ON:   prdata = {63'd0, sink_on};
      default:                prdata = '0;
    endcase
  end

  sac_front #(.DIMENSIONS(DIMENSIONS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_data     (s_tdata),
    .in_ghost    (s_tuser),
    .hole        ({hole_z, hole_y, hole_x}),
    .soften_sq   (soften_sq),
    .sink_rad_sq (sink_rad_sq),
    .sink_on     (sink_on),
    .push        (push),
    .push_job    (push_job),
    .q_not_full  (q_not_full)
  );

  sac_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .not_full  (q_not_full),
    .pop       (pop),
    .pop_job   (pop_job),
    .not_empty (q_not_empty)
  );

  sac_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (pop_job),
    .job_valid   (q_not_empty),
    .job_pop     (pop),
    .grav_mass   (grav_mass),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_accrete (m_tuser),
    .out_count   (out_count),
    .out_mass    (out_mass)
  );

  assign m_tdata = {out_mass, out_count};

endmodule

// ===== rtl/sac_checker.sv =====
// sac_checker: port-level checks of the sink accretion classifier
// bound to the top level; sees only its ports
module sac_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic        m_tuser
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // an accretion always leaves a nonzero count
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[31:0] != 32'd0)
    else $error("accretion with zero count");

  // no accretion so far means no mass so far
  a_mass: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[31:0] == 32'd0 |-> m_tdata[79:32] == 48'd0)
    else $error("mass without accretions");

endmodule

bind sink_accretion_classifier sac_checker u_sac_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== sim/sink_accretion_classifier_tb.sv =====
// sink_accretion_classifier_tb: self-checking bench for the sink accretion classifier
// drives particle words, predicts each accrete decision and running totals, checks in order
// depends on sac_pkg and sink_accretion_classifier
module sink_accretion_classifier_tb;

  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];
    logic [31:0]        mass;
    logic               ghost;
  } particle_t;

  typedef struct {
    logic        accrete;
    logic [31:0] count;
    logic [47:0] mass;
  } verdict_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [223:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [79:0]  m_tdata;
  logic         m_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [5:0]   paddr;
  logic [63:0]  pwdata;
  logic [63:0]  prdata;
  logic         pready;

  // predictor copy of the registers and totals
  logic signed [31:0] hole [3];
  logic [47:0]        grav_mass;
  logic [62:0]        soften_sq;
  logic [62:0]        sink_rad_sq;
  logic               sink_on;
  logic [31:0]        swallowed_count;
  logic [47:0]        swallowed_mass;

  particle_t pending_q [$];
  verdict_t  verdict_q [$];
  int        mismatches;
  int        words_in;
  int        idle_cycles;
  bit        quiet;

  sink_accretion_classifier i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] step;
    logic [63:0] rem;
    res = 0;
    rem = n;
    step = 64'h4000_0000_0000_0000;
    while (step > rem) step >>= 2;
    while (step != 0) begin
      if (rem >= res + step) begin
        rem -= res + step;
        res = (res >> 1) + step;
      end else begin
        res >>= 1;
      end
      step >>= 2;
    end
    return res;
  endfunction

  // decide whether the hole swallows this particle
  function automatic logic swallows(particle_t p);
    logic signed [33:0] d;
    logic signed [33:0] v;
    logic [32:0]        dm;
    logic [32:0]        vm;
    logic [67:0]        r2;
    logic [67:0]        pos_dot;
    logic [67:0]        neg_dot;
    logic [67:0]        vsq;
    logic [64:0]        rs;
    logic [63:0]        s;
    logic [63:0]        phi;
    logic [63:0]        ke;
    r2 = 0;
    pos_dot = 0;
    neg_dot = 0;
    vsq = 0;
    if (!sink_on || p.ghost) return 1'b0;
    for (int k = 0; k < 3; k++) begin
      d = 34'(p.pos[k]) - 34'(hole[k]);
      dm = d < 0 ? 33'(-d) : 33'(d);
      r2 += 68'(dm) * 68'(dm);
    end
    // a sum of squares past 64 bits counts as outside
    if (r2 > 68'hFFFF_FFFF_FFFF_FFFF) return 1'b0;
    if (r2 >= 68'(sink_rad_sq)) return 1'b0;
    for (int k = 0; k < 3; k++) begin
      d = 34'(p.pos[k]) - 34'(hole[k]);
      v = 34'(p.vel[k]);
      dm = d < 0 ? 33'(-d) : 33'(d);
      vm = v < 0 ? 33'(-v) : 33'(v);
      if ((v < 0) != (d < 0)) neg_dot += 68'(vm) * 68'(dm);
      else pos_dot += 68'(vm) * 68'(dm);
      vsq += 68'(vm) * 68'(vm);
    end
    if (!(neg_dot > pos_dot)) return 1'b0;
    rs = 65'(r2) + 65'(soften_sq);
    if (rs[64]) rs = 65'h0_FFFF_FFFF_FFFF_FFFF;
    s = floor_root(rs[63:0]);
    phi = (s == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : ({grav_mass, 16'h0} / s);
    ke = 64'(vsq >> 17);
    return ke < phi;
  endfunction

  // input side: accept, predict, count
  always @(posedge clk) begin
    verdict_t vd;
    logic [48:0] msum;
    if (!rst && s_tvalid && s_tready) begin
      particle_t p;
      for (int k = 0; k < 3; k++) begin
        p.pos[k] = s_tdata[32*k +: 32];
        p.vel[k] = s_tdata[96 + 32*k +: 32];
      end
      p.mass = s_tdata[192 +: 32];
      p.ghost = s_tuser;
      vd.accrete = swallows(p);
      if (vd.accrete) begin
        if (swallowed_count != 32'hFFFF_FFFF) swallowed_count = swallowed_count + 1;
        msum = 49'(swallowed_mass) + 49'(p.mass);
        swallowed_mass = msum[48] ? 48'hFFFF_FFFF_FFFF : msum[47:0];
      end
      vd.count = swallowed_count;
      vd.mass = swallowed_mass;
      verdict_q.insert(verdict_q.size(), vd);
      words_in++;
    end
  end

  // output side: compare with the oldest prediction
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: accrete %0b count %0d mass %0d",
                                       m_tuser, m_tdata[31:0], m_tdata[79:32]);
      end else begin
        want = verdict_q.pop_front();
        if (m_tuser !== want.accrete || m_tdata[31:0] !== want.count ||
            m_tdata[79:32] !== want.mass) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected accrete %0b count %0d mass %0d, got %0b %0d %0d",
                     want.accrete, want.count, want.mass,
                     m_tuser, m_tdata[31:0], m_tdata[79:32]);
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sink_accretion_classifier verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // driver: offer pending particles with random gaps
  int gap_left;
  always @(negedge clk) begin
    logic         nv;
    logic [223:0] nd;
    logic         nu;
    particle_t    p;
    nv = s_tvalid;
    nd = s_tdata;
    nu = s_tuser;
    if (rst) begin
      nv = 1'b0;
    end else if (!s_tvalid || s_tready) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 9) - 1;
      end else if (pending_q.size() != 0) begin
        p = pending_q.pop_front();
        for (int k = 0; k < 3; k++) begin
          nd[32*k +: 32] = p.pos[k];
          nd[96 + 32*k +: 32] = p.vel[k];
        end
        nd[192 +: 32] = p.mass;
        nu = p.ghost;
        nv = 1'b1;
      end
    end
    s_tvalid <= nv;
    s_tdata <= nd;
    s_tuser <= nu;
  end

  // receiver: random stalls plus one long hold-off
  int  hold_left;
  bit  long_done;
  always @(negedge clk) begin
    logic nr;
    nr = 1'b1;
    if (!long_done && words_in >= 300) begin
      long_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      nr = 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(1, 9) - 1;
      nr = 1'b0;
    end
    m_tready <= nr;
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      sac_pkg::REG_HOLE_X:    hole[0] = value[31:0];
      sac_pkg::REG_HOLE_Y:    hole[1] = value[31:0];
      sac_pkg::REG_HOLE_Z:    hole[2] = value[31:0];
      sac_pkg::REG_GRAV_MASS: grav_mass = value[47:0];
      sac_pkg::REG_SOFTEN_SQ: soften_sq = value[62:0];
      sac_pkg::REG_SINK_RAD:  sink_rad_sq = value[62:0];
      sac_pkg::REG_SINK_ON:   sink_on = value[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !s_tvalid && verdict_q.size() == 0);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_mag();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 16);
      1: return $urandom_range(0, 4096);
      2: return $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  // particle near the hole, mostly falling in
  task automatic add_near(int unsigned reach);
    particle_t p;
    int signed d;
    int signed vm;
    vm = rnd_mag() >> $urandom_range(0, 12);
    for (int k = 0; k < 3; k++) begin
      d = $urandom_range(0, 2 * reach) - reach;
      p.pos[k] = hole[k] + d;
      p.vel[k] = $urandom_range(0, 7) == 0 ? $signed($urandom % (vm + 1)) :
                 (d > 0 ? -$signed($urandom % (vm + 1)) : $signed($urandom % (vm + 1)));
    end
    p.mass = rnd_mag();
    p.ghost = $urandom_range(0, 9) == 0;
    pending_q.insert(pending_q.size(), p);
  endtask

  task automatic add_noise();
    particle_t p;
    for (int k = 0; k < 3; k++) begin
      p.pos[k] = $urandom;
      p.vel[k] = $urandom;
    end
    p.mass = $urandom;
    p.ghost = $urandom_range(0, 1);
    pending_q.insert(pending_q.size(), p);
  endtask

  task automatic add_fixed(logic signed [31:0] ps, logic signed [31:0] vl,
                           logic [31:0] m, logic g);
    particle_t p;
    for (int k = 0; k < 3; k++) begin
      p.pos[k] = ps;
      p.vel[k] = vl;
    end
    p.mass = m;
    p.ghost = g;
    pending_q.insert(pending_q.size(), p);
  endtask

  initial begin
    int unsigned reach;
    logic [63:0] rad;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet = 1'b0;
    mismatches = 0;
    words_in = 0;
    idle_cycles = 0;
    gap_left = 0;
    hold_left = 0;
    long_done = 1'b0;
    hole = '{0, 0, 0};
    grav_mass = sac_pkg::GRAV_MASS_RST;
    soften_sq = sac_pkg::SOFTEN_SQ_RST;
    sink_rad_sq = sac_pkg::SINK_RAD_RST;
    sink_on = 1'b1;
    swallowed_count = 0;
    swallowed_mass = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, zero distance, ghost, inflow vs outflow
    add_fixed(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_fixed(32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF, 1'b0);
    add_fixed(0, 0, 32'h0001_0000, 1'b0);
    add_fixed(0, -5, 32'h0001_0000, 1'b0);
    add_fixed(100, -5, 32'h0001_0000, 1'b0);
    add_fixed(100, -5, 32'h0001_0000, 1'b1);
    add_fixed(100, 5, 32'h0001_0000, 1'b0);
    add_fixed(-100, 5, 32'hFFFF_FFFF, 1'b0);
    add_fixed(-100, 32'sh7FFF_FFFF, 32'h0002_0000, 1'b0);
    add_fixed(189, -1, 32'h0001_0000, 1'b0);
    add_fixed(190, -1, 32'h0001_0000, 1'b0);
    add_fixed(1, -1, 0, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: begin
            // every register but the sink enable at its low end
            reg_write(sac_pkg::REG_HOLE_X, 64'hFFFF_FFFF_8000_0000);
            reg_write(sac_pkg::REG_HOLE_Y, 64'hFFFF_FFFF_8000_0000);
            reg_write(sac_pkg::REG_HOLE_Z, 64'hFFFF_FFFF_8000_0000);
            reg_write(sac_pkg::REG_GRAV_MASS, 0);
            reg_write(sac_pkg::REG_SOFTEN_SQ, 0);
            reg_write(sac_pkg::REG_SINK_RAD, 0);
            reg_write(sac_pkg::REG_SINK_ON, 1);
          end
          2: begin
            // high end: huge radius, strong hole
            reg_write(sac_pkg::REG_HOLE_X, 32'h7FFF_FFFF);
            reg_write(sac_pkg::REG_HOLE_Y, 32'h7FFF_FFFF);
            reg_write(sac_pkg::REG_HOLE_Z, 32'h7FFF_FFFF);
            reg_write(sac_pkg::REG_GRAV_MASS, 48'hFFFF_FFFF_FFFF);
            reg_write(sac_pkg::REG_SOFTEN_SQ, 63'h7FFF_FFFF_FFFF_FFFF);
            reg_write(sac_pkg::REG_SINK_RAD, 63'h7FFF_FFFF_FFFF_FFFF);
          end
          3: reg_write(sac_pkg::REG_SINK_ON, 0);
          default: begin
            reg_write(sac_pkg::REG_SINK_ON, $urandom_range(0, 5) != 0);
            reg_write(sac_pkg::REG_HOLE_X, rnd_mag());
            reg_write(sac_pkg::REG_HOLE_Y, -$signed(rnd_mag() >> 1));
            reg_write(sac_pkg::REG_HOLE_Z, $urandom);
            reg_write(sac_pkg::REG_GRAV_MASS, {$urandom, $urandom} >> $urandom_range(16, 63));
            reg_write(sac_pkg::REG_SOFTEN_SQ, {$urandom, $urandom} >> $urandom_range(1, 63));
            reg_write(sac_pkg::REG_SINK_RAD, {$urandom, $urandom} >> $urandom_range(1, 63));
          end
        endcase
        if (ph == 4) reg_write(sac_pkg::REG_SOFTEN_SQ, 0);
      end
      if (ph == 7) quiet = 1'b1;
      rad = floor_root({1'b0, sink_rad_sq});
      reach = rad > 64'h4000_0000 ? 32'h4000_0000 : rad[31:0];
      for (int n = 0; n < 115; n++) begin
        if ($urandom_range(0, 4) == 0) add_noise();
        else add_near($urandom_range(0, 3) == 0 ? reach + 4 : (reach >> 1) + 1);
      end
    end

    drain();
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("sink_accretion_classifier verification clean");
    end else begin
      $display("sink_accretion_classifier verification failed");
    end
    $finish;
  end

endmodule

// ===== sink_accretion_classifier.f =====
rtl/sac_pkg.sv
rtl/sac_queue.sv
rtl/sac_front.sv
rtl/sac_back.sv
rtl/sink_accretion_classifier.sv
rtl/sac_checker.sv
sim/sink_accretion_classifier_tb.sv
